// File: hw/rtl/tga_uncompressed_to_dib_writer_defines.svh
// Assertion macros shared by the TGA to bitmap writer RTL.
// Standalone header; the asserting modules include it by name.
`ifndef TGA_UNCOMPRESSED_TO_DIB_WRITER_DEFINES_SVH
`define TGA_UNCOMPRESSED_TO_DIB_WRITER_DEFINES_SVH

`ifndef SYNTH
// Concurrent assertion on an explicit clock and active-low reset.
`define TGADIB_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Concurrent assertion on the block clock and reset.
`define TGADIB_ASSERT(lbl, prop, msg) \
  `TGADIB_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define TGADIB_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define TGADIB_ASSERT(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/tgadib_pkg.sv
// Types and constants of the TGA to bitmap writer.
// No dependencies; used by tgadib_core and the top level.
`timescale 1ns / 1ps

package tgadib_pkg;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PhHeader = 4'b0001,
    PhId     = 4'b0010,
    PhPixel  = 4'b0100,
    PhIdle   = 4'b1000
  } phase_e;

  // Result kind carried on the output tuser.
  typedef enum logic [1:0] {
    KindWrite    = 2'd0,
    KindHeader   = 2'd1,
    KindBadType  = 2'd2,
    KindBadDepth = 2'd3
  } kind_e;

  // Header byte offsets.
  localparam logic [4:0] HdrIdLen    = 5'd0;
  localparam logic [4:0] HdrMapType  = 5'd1;
  localparam logic [4:0] HdrImgType  = 5'd2;
  localparam logic [4:0] HdrWidthLo  = 5'd12;
  localparam logic [4:0] HdrWidthHi  = 5'd13;
  localparam logic [4:0] HdrHeightLo = 5'd14;
  localparam logic [4:0] HdrHeightHi = 5'd15;
  localparam logic [4:0] HdrDepth    = 5'd16;
  localparam logic [4:0] HdrDesc     = 5'd17;

  localparam logic [7:0] MapTypeNone      = 8'd0;
  localparam logic [7:0] ImgTypeTrueColor = 8'd2;
  localparam logic [7:0] Depth16          = 8'd16;
  localparam logic [7:0] Depth24          = 8'd24;
  localparam logic [7:0] Depth32          = 8'd32;

  // Descriptor bit that selects the top-down row order.
  localparam int unsigned DescTopDownBit = 5;

  // Index of the last of the three writes of a 16-bit pixel.
  localparam logic [1:0] LastSub = 2'd2;

  // Register byte address of dest_base.
  localparam logic [2:0] RegDestBase = 3'd0;

  // Step handshake between the core and the top level.
  typedef struct packed {
    logic has_res;  // this step produces a result
    logic consume;  // this step finishes the input byte
  } step_ctl_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] addr;
    logic [7:0]  data;
    logic [15:0] width;
    logic [15:0] height;
    logic [17:0] stride;
    logic        done;
    logic        last;
  } result_t;

endpackage

// File: hw/rtl/tga_uncompressed_to_dib_writer.sv
// Top level of the TGA type 2 to bitmap byte-write converter.
// Depends on tgadib_pkg, tgadib_core and the assertion macro header.
`timescale 1ns / 1ps
`include "tga_uncompressed_to_dib_writer_defines.svh"

// The block takes a TGA file as a stream of bytes on the slave channel, one byte per
// transaction, with tuser marking the first byte of a new file. It parses the 18-byte
// header, skips the ID field and turns the pixel data into byte writes of a bitmap at
// dest_base, with rows padded to a multiple of four bytes. Results leave on the master
// channel, one per transaction: tuser gives the kind, tlast marks the final result of
// an input byte, and tdata carries address, data, header fields and the done flag.
// The APB port writes and reads dest_base; it is sampled when a header is accepted.
// An accepted byte is held in the input register, its first result in the output
// register. A 24-bit or 32-bit pixel byte gives one write; a 16-bit pixel gives none
// for its low byte and three for its high byte, as the result register takes one
// write per cycle unless the receiver stalls. The input register holds one byte and
// the output register one result, so a new byte is accepted while a result waits.
// After reset all parse state is clear and the first byte is taken as header byte 0.
// When the receiver stalls, the pending result holds, the parse pauses, and tready on
// the slave side drops once the input register is occupied.

module tga_uncompressed_to_dib_writer #(
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input byte stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  logic        s_axis_tuser_i,   // [0] frame_start
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,   // [31:0] write_address, [39:32] write_data,
                                        // [55:40] image_width, [71:56] image_height,
                                        // [89:72] row_stride, [90] image_done, rest 0
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tgadib_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        in_fs_q;
  logic        out_valid_q, out_valid_d;
  result_t     out_q;
  logic [31:0] dest_base_q;

  step_ctl_t   ctl;
  result_t     res;
  logic        out_free;
  logic        fire;
  logic        in_take;

  // Configuration registers. pready is tied high, so every access completes
  // in its access cycle.
  assign pready = 1'b1;
  assign prdata = (paddr == RegDestBase) ? dest_base_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_base_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == RegDestBase[2])) begin
      dest_base_q <= pwdata;
    end
  end

  // A step runs whenever a byte is held and, if it makes a result, the output
  // register is empty or being drained in this cycle.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && (!ctl.has_res || out_free);
  assign s_axis_tready_o = !in_valid_q || (fire && ctl.consume);
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  tgadib_core #(
    .ADDR_BITS(ADDR_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_en_i    (fire),
    .byte_i       (in_byte_q),
    .frame_start_i(in_fs_q),
    .dest_base_i  (dest_base_q),
    .ctl_o        (ctl),
    .res_o        (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire && ctl.consume) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire && ctl.has_res) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
      in_fs_q   <= s_axis_tuser_i;
    end
    if (fire && ctl.has_res) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {5'd0, out_q.done, out_q.stride, out_q.height,
                            out_q.width, out_q.data, out_q.addr};

  `TGADIB_ASSERT(a_result_loaded, (fire && ctl.has_res) |=> out_valid_q,
                 "produced result did not reach the output register")
  `TGADIB_ASSERT(a_input_holds, (in_valid_q && !fire) |=> (in_valid_q && $stable(in_byte_q)),
                 "held input byte lost while the step was blocked")
  `TGADIB_ASSERT(a_status_last, (out_valid_q && (out_q.kind != KindWrite)) |-> out_q.last,
                 "header status result not marked last")

endmodule

// File: hw/rtl/tgadib_core.sv
// Header parser and bitmap address generator of the TGA to bitmap writer.
// Depends on tgadib_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "tga_uncompressed_to_dib_writer_defines.svh"

module tgadib_core #(
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_en_i,
  input  logic [7:0]           byte_i,
  input  logic                 frame_start_i,
  input  logic [31:0]          dest_base_i,
  output tgadib_pkg::step_ctl_t ctl_o,
  output tgadib_pkg::result_t  res_o
);
  import tgadib_pkg::*;

  localparam int unsigned ExtBits = (ADDR_BITS > 32) ? ADDR_BITS : 32;

  phase_e                 phase_q, phase_d, phase_eff;
  logic [4:0]             hdr_idx_q, hdr_idx_d, idx_eff;
  logic [7:0]             id_len_q, id_len_d;
  logic [5:0]             depth_q, depth_d;
  logic                   top_down_q, top_down_d;
  logic [15:0]            width_q, width_d;
  logic [15:0]            height_q, height_d;
  logic [7:0]             id_rem_q, id_rem_d;
  logic [17:0]            col_q, col_d;
  logic [15:0]            row_q, row_d;
  logic [ADDR_BITS-1:0]   row_addr_q, row_addr_d;
  logic [ADDR_BITS-1:0]   wp_q, wp_d;
  logic [17:0]            stride_q, stride_d;
  logic [17:0]            row_len_q, row_len_d;
  logic [7:0]             held_q, held_d;
  logic                   byte_phase_q, byte_phase_d;
  logic                   type_bad_q, type_bad_d, tb_eff;
  logic                   depth_bad_q, depth_bad_d, db_eff;
  logic [1:0]             sub_q, sub_d;

  // Shared write-step datapath.
  logic [17:0]            col_inc;
  logic                   row_end;
  logic [15:0]            row_inc;
  logic [ADDR_BITS-1:0]   stride_a;
  logic [ADDR_BITS-1:0]   next_row_addr;
  logic                   wr_done;
  logic [ExtBits-1:0]     wp_ext;
  logic                   do_write;
  logic [7:0]             wr_data;

  // Header arithmetic.
  logic                   is32;
  logic [17:0]            len_calc;
  logic [18:0]            len_round;
  logic [33:0]            top_prod;
  logic [ADDR_BITS-1:0]   row_start;
  logic                   empty;

  assign col_inc       = col_q + 18'd1;
  assign row_end       = (col_inc >= row_len_q);
  assign row_inc       = row_q + 16'd1;
  assign stride_a      = ADDR_BITS'(stride_q);
  assign next_row_addr = top_down_q ? (row_addr_q - stride_a) : (row_addr_q + stride_a);
  assign wr_done       = row_end && (row_inc >= height_q);
  assign wp_ext        = ExtBits'(wp_q);

  assign is32      = (byte_i[5:0] == Depth32[5:0]);
  assign len_calc  = is32 ? {width_q, 2'b00} : ({1'b0, width_q, 1'b0} + {2'b00, width_q});
  assign len_round = {1'b0, len_calc} + 19'd3;
  assign top_prod  = 34'(stride_q) * 34'(height_q - 16'd1);
  assign row_start = ADDR_BITS'(dest_base_i) +
                     ((byte_i[DescTopDownBit] && (height_q != 16'd0)) ?
                      ADDR_BITS'(top_prod) : '0);
  assign empty     = (width_q == 16'd0) || (height_q == 16'd0);

  always_comb begin
    // A frame start restarts the header parse before the byte is handled.
    phase_eff = phase_q;
    idx_eff   = hdr_idx_q;
    tb_eff    = type_bad_q;
    db_eff    = depth_bad_q;
    if ((sub_q == 2'd0) && frame_start_i) begin
      phase_eff = PhHeader;
      idx_eff   = HdrIdLen;
      tb_eff    = 1'b0;
      db_eff    = 1'b0;
    end

    phase_d      = phase_eff;
    hdr_idx_d    = idx_eff;
    type_bad_d   = tb_eff;
    depth_bad_d  = db_eff;
    id_len_d     = id_len_q;
    depth_d      = depth_q;
    top_down_d   = top_down_q;
    width_d      = width_q;
    height_d     = height_q;
    id_rem_d     = id_rem_q;
    col_d        = col_q;
    row_d        = row_q;
    row_addr_d   = row_addr_q;
    wp_d         = wp_q;
    stride_d     = stride_q;
    row_len_d    = row_len_q;
    held_d       = held_q;
    byte_phase_d = byte_phase_q;
    sub_d        = sub_q;
    do_write     = 1'b0;
    wr_data      = byte_i;
    ctl_o        = '0;
    res_o        = '0;
    res_o.kind   = KindWrite;

    if (sub_q != 2'd0) begin
      // Second and third writes of a 16-bit pixel.
      do_write      = 1'b1;
      ctl_o.has_res = 1'b1;
      if (sub_q == LastSub) begin
        wr_data       = {byte_i[6:2], 3'b000};
        sub_d         = 2'd0;
        ctl_o.consume = 1'b1;
      end else begin
        wr_data = {byte_i[1:0], held_q[7:5], 3'b000};
        sub_d   = sub_q + 2'd1;
      end
    end else begin
      case (phase_eff)
        PhHeader: begin
          ctl_o.consume = 1'b1;
          hdr_idx_d     = idx_eff + 5'd1;
          case (idx_eff)
            HdrIdLen:    id_len_d = byte_i;
            HdrMapType:  if (byte_i != MapTypeNone) type_bad_d = 1'b1;
            HdrImgType:  if (byte_i != ImgTypeTrueColor) type_bad_d = 1'b1;
            HdrWidthLo:  width_d[7:0] = byte_i;
            HdrWidthHi:  width_d[15:8] = byte_i;
            HdrHeightLo: height_d[7:0] = byte_i;
            HdrHeightHi: height_d[15:8] = byte_i;
            HdrDepth: begin
              depth_bad_d = !((byte_i == Depth16) || (byte_i == Depth24) ||
                              (byte_i == Depth32));
              depth_d     = byte_i[5:0];
              row_len_d   = len_calc;
              stride_d    = {len_round[17:2], 2'b00};
            end
            HdrDesc: begin
              top_down_d    = byte_i[DescTopDownBit];
              ctl_o.has_res = 1'b1;
              if (tb_eff) begin
                res_o.kind = KindBadType;
                phase_d    = PhIdle;
              end else if (db_eff) begin
                res_o.kind = KindBadDepth;
                phase_d    = PhIdle;
              end else begin
                row_addr_d   = row_start;
                wp_d         = row_start;
                col_d        = '0;
                row_d        = '0;
                byte_phase_d = 1'b0;
                held_d       = '0;
                id_rem_d     = id_len_q;
                res_o.kind   = KindHeader;
                res_o.width  = width_q;
                res_o.height = height_q;
                res_o.stride = stride_q;
                res_o.done   = empty;
                if (empty) begin
                  phase_d = PhIdle;
                end else if (id_len_q != 8'd0) begin
                  phase_d = PhId;
                end else begin
                  phase_d = PhPixel;
                end
              end
            end
            default: ;
          endcase
        end
        PhId: begin
          ctl_o.consume = 1'b1;
          id_rem_d      = id_rem_q - 8'd1;
          if (id_rem_q == 8'd1) phase_d = PhPixel;
        end
        PhPixel: begin
          if (depth_q == Depth16[5:0]) begin
            if (!byte_phase_q) begin
              held_d        = byte_i;
              byte_phase_d  = 1'b1;
              ctl_o.consume = 1'b1;
            end else begin
              byte_phase_d  = 1'b0;
              do_write      = 1'b1;
              wr_data       = {held_q[4:0], 3'b000};
              sub_d         = 2'd1;
              ctl_o.has_res = 1'b1;
            end
          end else begin
            do_write      = 1'b1;
            ctl_o.has_res = 1'b1;
            ctl_o.consume = 1'b1;
          end
        end
        default: begin
          ctl_o.consume = 1'b1;
          phase_d       = PhIdle;
        end
      endcase
    end

    if (do_write) begin
      res_o.kind = KindWrite;
      res_o.addr = wp_ext[31:0];
      res_o.data = wr_data;
      wp_d       = wp_q + ADDR_BITS'(1);
      col_d      = col_inc;
      if (row_end) begin
        col_d      = '0;
        row_d      = row_inc;
        row_addr_d = next_row_addr;
        wp_d       = next_row_addr;
        if (wr_done) begin
          res_o.done = 1'b1;
          phase_d    = PhIdle;
        end
      end
    end

    res_o.last = ctl_o.consume;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHeader;
      hdr_idx_q    <= '0;
      id_len_q     <= '0;
      depth_q      <= '0;
      top_down_q   <= 1'b0;
      width_q      <= '0;
      height_q     <= '0;
      id_rem_q     <= '0;
      col_q        <= '0;
      row_q        <= '0;
      row_addr_q   <= '0;
      wp_q         <= '0;
      stride_q     <= '0;
      row_len_q    <= '0;
      held_q       <= '0;
      byte_phase_q <= 1'b0;
      type_bad_q   <= 1'b0;
      depth_bad_q  <= 1'b0;
      sub_q        <= '0;
    end else if (step_en_i) begin
      phase_q      <= phase_d;
      hdr_idx_q    <= hdr_idx_d;
      id_len_q     <= id_len_d;
      depth_q      <= depth_d;
      top_down_q   <= top_down_d;
      width_q      <= width_d;
      height_q     <= height_d;
      id_rem_q     <= id_rem_d;
      col_q        <= col_d;
      row_q        <= row_d;
      row_addr_q   <= row_addr_d;
      wp_q         <= wp_d;
      stride_q     <= stride_d;
      row_len_q    <= row_len_d;
      held_q       <= held_d;
      byte_phase_q <= byte_phase_d;
      type_bad_q   <= type_bad_d;
      depth_bad_q  <= depth_bad_d;
      sub_q        <= sub_d;
    end
  end

  `TGADIB_ASSERT(a_sub_range, sub_q != 2'd3, "pixel write counter out of range")
  `TGADIB_ASSERT(a_sub_depth, (sub_q != 2'd0) |-> (depth_q == Depth16[5:0]),
                 "multi-write step outside a 16-bit image")
  `TGADIB_ASSERT(a_id_nonzero, (phase_q == PhId) |-> (id_rem_q != 8'd0),
                 "ID skip phase with nothing left to skip")

endmodule

// File: tb/sv/tgadib_tb_pkg.sv
// Scoreboard for the TGA to bitmap writer testbench: a cycle-free decoder
// that predicts the result transactions of each file byte, plus the checker.
// Depends on tgadib_pkg for the result kinds, parse phases and header offsets.
`timescale 1ns / 1ps

package tgadib_tb_pkg;

  import tgadib_pkg::*;

  class dib_writer_scoreboard;

    int fail_count = 0;

    // Results still owed by the block, oldest first.
    result_t awaited[$];

    logic [31:0] base_addr   = '0;
    phase_e      phase       = PhHeader;
    logic [4:0]  hdr_idx     = '0;
    logic [7:0]  id_len      = '0;
    logic [5:0]  depth       = '0;
    logic        top_down    = 1'b0;
    logic [15:0] width       = '0;
    logic [15:0] height      = '0;
    logic [7:0]  id_left     = '0;
    logic [17:0] col         = '0;
    logic [15:0] rows        = '0;
    logic [31:0] row_addr    = '0;
    logic [31:0] wptr        = '0;
    logic [18:0] stride      = '0;
    logic [7:0]  held_low    = '0;
    logic        high_next   = 1'b0;
    logic        type_bad    = 1'b0;
    logic        depth_bad   = 1'b0;

    function void set_base(logic [31:0] v);
      base_addr = v;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void mismatch(string what, logic [63:0] want, logic [63:0] got);
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
    endfunction

    function void cmp(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) mismatch(what, want, got);
    endfunction

    function void emit(kind_e k, logic [31:0] a, logic [7:0] d, logic [15:0] w,
                       logic [15:0] h, logic [17:0] s, logic dn);
      result_t r;
      r.kind   = k;
      r.addr   = a;
      r.data   = d;
      r.width  = w;
      r.height = h;
      r.stride = s;
      r.done   = dn;
      r.last   = 1'b0;
      awaited.push_back(r);
    endfunction

    // One bitmap byte write, advancing the column, the row and the image.
    function void emit_pixel_byte(logic [7:0] d);
      logic [31:0] row_len;
      logic [31:0] a;
      logic        dn;
      row_len = {16'd0, width} * (({2'b00, depth} == Depth32) ? 32'd4 : 32'd3);
      a    = wptr;
      dn   = 1'b0;
      wptr = wptr + 32'd1;
      col  = col + 18'd1;
      if ({14'd0, col} >= row_len) begin
        col  = '0;
        rows = rows + 16'd1;
        if (top_down) row_addr = row_addr - {13'd0, stride};
        else row_addr = row_addr + {13'd0, stride};
        wptr = row_addr;
        if (rows >= height) begin
          dn    = 1'b1;
          phase = PhIdle;
        end
      end
      emit(KindWrite, a, d, '0, '0, '0, dn);
    endfunction

    function void parse_header_byte(logic [7:0] b);
      logic [4:0]  idx;
      logic [31:0] bits;
      logic [31:0] words;
      logic [63:0] span;
      logic        empty;
      idx     = hdr_idx;
      hdr_idx = hdr_idx + 5'd1;
      case (idx)
        HdrIdLen:    id_len = b;
        HdrMapType:  if (b != MapTypeNone) type_bad = 1'b1;
        HdrImgType:  if (b != ImgTypeTrueColor) type_bad = 1'b1;
        HdrWidthLo:  width[7:0] = b;
        HdrWidthHi:  width[15:8] = b;
        HdrHeightLo: height[7:0] = b;
        HdrHeightHi: height[15:8] = b;
        HdrDepth: begin
          depth_bad = !(b == Depth16 || b == Depth24 || b == Depth32);
          depth     = b[5:0];
        end
        HdrDesc: begin
          top_down = b[DescTopDownBit];
          if (type_bad) begin
            emit(KindBadType, '0, '0, '0, '0, '0, 1'b0);
            phase = PhIdle;
          end else if (depth_bad) begin
            emit(KindBadDepth, '0, '0, '0, '0, '0, 1'b0);
            phase = PhIdle;
          end else begin
            // A 16-bit pixel expands to three bytes in the bitmap.
            bits = {16'd0, width} *
                   (({2'b00, depth} == Depth16) ? 32'(Depth24) : {26'd0, depth});
            words  = (bits + 32'd31) / 32'd32;
            stride = 19'(words * 32'd4);
            row_addr = base_addr;
            if (top_down && height != 16'd0) begin
              span     = 64'(stride) * 64'(height - 16'd1);
              row_addr = base_addr + span[31:0];
            end
            wptr      = row_addr;
            col       = '0;
            rows      = '0;
            high_next = 1'b0;
            held_low  = '0;
            id_left   = id_len;
            empty     = (width == 16'd0) || (height == 16'd0);
            emit(KindHeader, '0, '0, width, height, stride[17:0], empty);
            if (empty) phase = PhIdle;
            else phase = (id_len != 8'd0) ? PhId : PhPixel;
          end
        end
        default: ;
      endcase
      if (idx >= HdrDesc && phase == PhHeader) phase = PhIdle;
    endfunction

    // Called for every accepted file byte; queues the results it causes.
    function void note_file_byte(logic [7:0] b, logic frame_start);
      int          n0;
      logic [15:0] px;
      result_t     r;
      n0 = awaited.size();
      if (frame_start) begin
        phase     = PhHeader;
        hdr_idx   = '0;
        type_bad  = 1'b0;
        depth_bad = 1'b0;
      end
      case (phase)
        PhHeader: parse_header_byte(b);
        PhId: begin
          id_left = id_left - 8'd1;
          if (id_left == 8'd0) phase = PhPixel;
        end
        PhPixel: begin
          if ({2'b00, depth} == Depth16) begin
            if (!high_next) begin
              held_low  = b;
              high_next = 1'b1;
            end else begin
              px        = {b, held_low};
              high_next = 1'b0;
              emit_pixel_byte({px[4:0], 3'b000});
              emit_pixel_byte({px[9:5], 3'b000});
              emit_pixel_byte({px[14:10], 3'b000});
            end
          end else begin
            emit_pixel_byte(b);
          end
        end
        default: phase = PhIdle;
      endcase
      if (awaited.size() > n0) begin
        r      = awaited.pop_back();
        r.last = 1'b1;
        awaited.push_back(r);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [95:0] bus, logic tl);
      result_t e;
      if (awaited.size() == 0) begin
        mismatch("unexpected result, address", '0, bus[31:0]);
        return;
      end
      e = awaited.pop_front();
      cmp("kind", e.kind, kind);
      cmp("write_address", e.addr, bus[31:0]);
      cmp("write_data", e.data, bus[39:32]);
      cmp("image_width", e.width, bus[55:40]);
      cmp("image_height", e.height, bus[71:56]);
      cmp("row_stride", e.stride, bus[89:72]);
      cmp("image_done", e.done, bus[90]);
      cmp("tdata padding", '0, bus[95:91]);
      cmp("tlast", e.last, tl);
    endfunction

    function void report_leftovers();
      if (awaited.size() != 0) begin
        $display("%0d expected results never arrived", awaited.size());
        fail_count += awaited.size();
      end
    endfunction

  endclass

endpackage

// File: tb/sv/tb_top.sv
// Top-level testbench of the TGA to bitmap writer: drives file bytes, the result
// stream and the APB port, and checks every result against the scoreboard.
// Depends on tgadib_pkg, tgadib_tb_pkg and the tga_uncompressed_to_dib_writer RTL.
`timescale 1ns / 1ps

module tb_top;

  import tgadib_pkg::*;
  import tgadib_tb_pkg::*;

  // A legal run never goes this many cycles without a transaction on either side;
  // the longest stall, gap, configuration access or pixel expansion is far shorter.
  localparam int StallLimit = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [95:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dib_writer_scoreboard sb = new();

  int sent_items = 0;
  int stall_cycles = 0;
  // While set, neither side inserts any gaps.
  bit steady = 1'b0;

  tga_uncompressed_to_dib_writer #(
    .ADDR_BITS(32)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mostly no gap or a short one, now and then a long one.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The result side alternates between ready stretches and stalls of random length.
  initial begin
    int gap;
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Outputs are sampled at the rising edge, before any flop of the block updates,
  // so each check sees exactly the values that formed the handshake at that edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_result(m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Watchdog: the block has hung if nothing moves for too long.
  initial begin
    wait (stall_cycles >= StallLimit);
    $display("DONE: errors detected");
    $finish;
  end

  // Offers one file byte and returns at the edge where the transaction completes.
  // Valid stays high into the next byte when no gap follows, so back-to-back
  // transactions are exercised.
  task send_byte(input logic [7:0] b, input logic fs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= fs;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_file_byte(b, fs);
    sent_items++;
  endtask

  // Stops sending and waits until every predicted result has been taken, then lets
  // the block settle; always advances at least one edge so no drive is doubled.
  task wait_drained(input int settle);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // APB write of dest_base followed by a read-back of the same register.
  task write_base(input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegDestBase;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_base(v);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.cmp("dest_base read-back", v, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // A complete file: 18 header bytes in little-endian order, the ID field and
  // n_px pixel bytes. The colour-map and origin bytes carry random filler.
  task send_frame(input int id_n, input logic [7:0] map, ity, input logic [15:0] w, h,
                  input logic [7:0] dep, desc, input int n_px, input logic fs0);
    send_byte(8'(id_n), fs0);
    send_byte(map, 1'b0);
    send_byte(ity, 1'b0);
    repeat (9) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(w[7:0], 1'b0);
    send_byte(w[15:8], 1'b0);
    send_byte(h[7:0], 1'b0);
    send_byte(h[15:8], 1'b0);
    send_byte(dep, 1'b0);
    send_byte(desc, 1'b0);
    repeat (id_n) send_byte(8'($urandom_range(0, 255)), 1'b0);
    repeat (n_px) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // One random file. Most are well-formed small images with random content and row
  // order; the rest are rejected headers, empty images, images cut short by the next
  // frame start, and plain noise.
  task random_frame();
    int         pick;
    int         w;
    int         h;
    int         idn;
    int         n_px;
    int         extra;
    logic [7:0] dep;
    logic [7:0] map;
    logic [7:0] ity;
    logic [7:0] desc;
    pick = $urandom_range(0, 99);
    if (pick >= 94) begin
      // Noise: random bytes opening a new file, mostly rejected, with restarts.
      n_px = $urandom_range(1, 24);
      for (int i = 0; i < n_px; i++) begin
        send_byte(8'($urandom_range(0, 255)), (i == 0) || ($urandom_range(0, 7) == 0));
      end
      return;
    end
    w    = $urandom_range(1, 3);
    h    = $urandom_range(1, 3);
    idn  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    map  = MapTypeNone;
    ity  = ImgTypeTrueColor;
    desc = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0:       dep = Depth16;
      1:       dep = Depth24;
      default: dep = Depth32;
    endcase
    if (pick < 8) begin
      // Bad colour map or type; sometimes a bad depth as well, which must lose.
      if ($urandom_range(0, 1)) map = 8'($urandom_range(1, 255));
      else begin
        do ity = 8'($urandom_range(0, 255)); while (ity == ImgTypeTrueColor);
      end
      if ($urandom_range(0, 1)) dep = 8'($urandom_range(0, 255));
    end else if (pick < 16) begin
      do dep = 8'($urandom_range(0, 255));
      while (dep == Depth16 || dep == Depth24 || dep == Depth32);
    end else if (pick < 21) begin
      // Empty image; a full-width one gives the largest row stride.
      if ($urandom_range(0, 1)) begin
        w = 0;
        h = $urandom_range(0, 65535);
      end else begin
        h = 0;
        w = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 65535);
      end
    end
    n_px = (dep == Depth16) ? w * h * 2 : w * h * (dep / 8);
    if (pick < 21) n_px = 0;
    else if ((n_px > 0) && ($urandom_range(0, 7) == 0)) n_px = $urandom_range(0, n_px - 1);
    send_frame(idn, map, ity, 16'(w), 16'(h), dep, desc, n_px, 1'b1);
    // Bytes after a finished or rejected file are ignored and do not count.
    extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (extra) send_byte(8'($urandom_range(0, 255)), 1'b0);
    sent_items -= extra;
  endtask

  initial begin
    logic [31:0] bases [4];
    int          target;
    bases[0] = 32'hFFFF_FFFF;
    bases[1] = $urandom();
    bases[2] = 32'h0000_0000;
    bases[3] = $urandom();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Right after reset the first byte is header byte 0 even without a frame start.
    // One 24-bit pixel at the reset base, then two bytes the finished image ignores.
    send_frame(0, MapTypeNone, ImgTypeTrueColor, 16'd1, 16'd1, Depth24, 8'h00, 3, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);

    // Largest 16-bit image, top row first, near the top of the address space so
    // the first row address wraps. Two pixels with every bit set and only bit 15 set,
    // then the image is abandoned by a header with both a bad type and a bad depth.
    wait_drained(8);
    write_base(32'hFFFF_FFF8);
    send_frame(1, MapTypeNone, ImgTypeTrueColor, 16'hFFFF, 16'hFFFF, Depth16, 8'h20, 0,
               1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_frame(0, 8'h01, 8'h0A, 16'd2, 16'd2, 8'hFF, 8'h00, 0, 1'b1);

    // Random part in four settings of dest_base, the extremes among them. Each
    // setting is written only after every result has come out. The third setting
    // runs without any gaps on either side.
    sent_items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained(8);
      write_base(bases[ph]);
      steady = (ph == 2);
      target = (ph + 1) * 36;
      while (sent_items < target) begin
        random_frame();
        // Occasionally hold off the sender until the block has emptied.
        if ($urandom_range(0, 9) == 0) wait_drained(0);
      end
    end
    steady = 1'b0;

    wait_drained(20);
    sb.report_leftovers();
    if (sb.fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: tga_uncompressed_to_dib_writer.f
+incdir+hw/rtl
hw/rtl/tgadib_pkg.sv
hw/rtl/tgadib_core.sv
hw/rtl/tga_uncompressed_to_dib_writer.sv
tb/sv/tgadib_tb_pkg.sv
tb/sv/tb_top.sv
